// File: hw/rtl/sqb_pkg.sv
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types and constants for the sprite quad batcher.
// ----------------------------------------------------------------------------
package sqb_pkg;

    localparam int DEF_MAX_QUADS     = 32;
    localparam int DEF_NUM_SLOTS     = 8;
    localparam int CMD_QUEUE_DEPTH   = 2;

    typedef enum logic {
        OP_DRAW  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BIND   = 2'd1,
        KIND_DRAW   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BIND,
        S_DRAW,
        S_VERT
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [31:0]        texture_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] width;
        logic signed [31:0] height;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic               tex_u;
        logic               tex_v;
        logic [2:0]         slot;
        logic [31:0]        bound_texture;
        logic [7:0]         index_count;
        logic               last;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        t_op                op;
        logic [31:0]        tex;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
    } t_cmd;

endpackage

// File: hw/rtl/sqb_front.sv
// ----------------------------------------------------------------------------
// sqb_front
// Accepts requests, computes the saturated far edges and queues a command.
// ----------------------------------------------------------------------------
module sqb_front (
    input  logic             i_valid,
    input  sqb_pkg::t_in_item i_item,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output sqb_pkg::t_cmd    o_cmd
);
    import sqb_pkg::*;

    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;

    assign sum_x = {i_item.pos_x[31], i_item.pos_x} + {i_item.width[31], i_item.width};
    assign sum_y = {i_item.pos_y[31], i_item.pos_y} + {i_item.height[31], i_item.height};

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.op  = i_item.operation;
        o_cmd.tex = i_item.texture_id;
        o_cmd.x0  = i_item.pos_x;
        o_cmd.y0  = i_item.pos_y;
        // clamp on overflow: top two bits disagree
        if (sum_x[32] != sum_x[31]) begin
            o_cmd.x1 = sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_cmd.x1 = sum_x[31:0];
        end
        if (sum_y[32] != sum_y[31]) begin
            o_cmd.y1 = sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_cmd.y1 = sum_y[31:0];
        end
    end

endmodule

// File: hw/rtl/sqb_fifo.sv
// ----------------------------------------------------------------------------
// sqb_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sqb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sqb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sqb_pkg::t_cmd o_cmd
);
    import sqb_pkg::*;

    localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

    t_cmd          r_mem [CMD_QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(CMD_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/sqb_back.sv
// ----------------------------------------------------------------------------
// sqb_back
// Executes queued commands: slot lookup, binds, draw, vertex emission.
// ----------------------------------------------------------------------------
module sqb_back #(
    parameter int MAX_QUADS = sqb_pkg::DEF_MAX_QUADS,
    parameter int NUM_SLOTS = sqb_pkg::DEF_NUM_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  sqb_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output sqb_pkg::t_out_item o_result
);
    import sqb_pkg::*;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUSED_W = $clog2(NUM_SLOTS + 1);
    localparam int QW      = $clog2(MAX_QUADS + 1);

    t_state             r_state, n_state;
    logic [31:0]        r_table [NUM_SLOTS];
    logic [SUSED_W-1:0] r_slots_used, n_slots_used;
    logic [QW-1:0]      r_quads, n_quads;
    logic [SLOT_W-1:0]  r_bind_idx, n_bind_idx;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [1:0]         r_vcnt, n_vcnt;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               adv;
    logic               emit;
    logic               tbl_we;
    t_out_item          n_res;
    logic               need_flush;
    logic               bind_done;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic [QW+2:0]      cnt6;

    // output register loads when empty or drained this cycle
    assign adv        = !r_out_valid || !i_stall;
    assign need_flush = (r_quads == QW'(MAX_QUADS)) ||
                        (r_slots_used == SUSED_W'(NUM_SLOTS));
    assign bind_done  = ((SUSED_W+1)'(r_bind_idx) + 1'b1) == (SUSED_W+1)'(r_slots_used);
    assign cnt6       = {1'b0, r_quads, 2'b00} + {2'b00, r_quads, 1'b0};

    // first matching occupied slot
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if ((SUSED_W'(i) < r_slots_used) && (r_table[i] == i_cmd.tex)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.op == OP_FLUSH) begin
                        if (r_quads != '0) begin
                            n_state = S_BIND;
                        end
                    end else if (need_flush) begin
                        n_state = S_BIND;
                    end else begin
                        n_state = S_VERT;
                    end
                end
            end
            S_BIND: begin
                if (adv && bind_done) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            S_VERT: begin
                if (adv && (r_vcnt == 2'd3)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        emit         = 1'b0;
        tbl_we       = 1'b0;
        n_res        = '0;
        n_slots_used = r_slots_used;
        n_quads      = r_quads;
        n_bind_idx   = r_bind_idx;
        n_slot       = r_slot;
        n_vcnt       = r_vcnt;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.op == OP_FLUSH) begin
                        if (r_quads == '0) begin
                            o_pop = 1'b1;
                        end else begin
                            n_bind_idx = '0;
                        end
                    end else if (need_flush) begin
                        n_bind_idx = '0;
                    end else begin
                        n_vcnt = '0;
                        if (hit) begin
                            n_slot = hit_idx;
                        end else begin
                            n_slot       = SLOT_W'(r_slots_used);
                            tbl_we       = 1'b1;
                            n_slots_used = r_slots_used + 1'b1;
                        end
                    end
                end
            end
            S_BIND: begin
                if (adv) begin
                    emit                = 1'b1;
                    n_res.kind          = KIND_BIND;
                    n_res.slot          = 3'(r_bind_idx);
                    n_res.bound_texture = r_table[r_bind_idx];
                    n_bind_idx          = r_bind_idx + 1'b1;
                end
            end
            S_DRAW: begin
                if (adv) begin
                    emit              = 1'b1;
                    n_res.kind        = KIND_DRAW;
                    n_res.index_count = 8'(cnt6);
                    n_res.last        = (i_cmd.op == OP_FLUSH);
                    n_quads           = '0;
                    n_slots_used      = '0;
                    o_pop             = (i_cmd.op == OP_FLUSH);
                end
            end
            S_VERT: begin
                if (adv) begin
                    emit       = 1'b1;
                    n_res.kind = KIND_VERTEX;
                    n_res.slot = 3'(r_slot);
                    n_vcnt     = r_vcnt + 1'b1;
                    case (r_vcnt)
                        2'd0: begin
                            n_res.vert_x = i_cmd.x0;
                            n_res.vert_y = i_cmd.y0;
                        end
                        2'd1: begin
                            n_res.vert_x = i_cmd.x1;
                            n_res.vert_y = i_cmd.y0;
                            n_res.tex_u  = 1'b1;
                        end
                        2'd2: begin
                            n_res.vert_x = i_cmd.x1;
                            n_res.vert_y = i_cmd.y1;
                            n_res.tex_u  = 1'b1;
                            n_res.tex_v  = 1'b1;
                        end
                        default: begin
                            n_res.vert_x = i_cmd.x0;
                            n_res.vert_y = i_cmd.y1;
                            n_res.tex_v  = 1'b1;
                            n_res.last   = 1'b1;
                            n_quads      = r_quads + 1'b1;
                            o_pop        = 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slots_used <= '0;
            r_quads      <= '0;
            r_bind_idx   <= '0;
            r_vcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slots_used <= n_slots_used;
            r_quads      <= n_quads;
            r_bind_idx   <= n_bind_idx;
            r_vcnt       <= n_vcnt;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (emit) begin
            r_out <= n_res;
        end
        if (tbl_we) begin
            r_table[SLOT_W'(r_slots_used)] <= i_cmd.tex;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: hw/rtl/sprite_quad_batcher.sv
// A draw request passes the queue write, the slot lookup and the output
//   register before its first vertex shows, when no flush is needed.
// Each quad takes a lookup plus four vertex results while the result
//   channel does not stall; a flush takes a decision, one bind per occupied
//   slot and the draw command.
// Reset: synchronous, active low; batch and slot counts cleared, queue empty.
// ----------------------------------------------------------------------------
// sprite_quad_batcher
// Collects textured quads into a batch; emits vertices, slot binds and draws.
// ----------------------------------------------------------------------------
module sprite_quad_batcher #(
    parameter int MAX_QUADS = sqb_pkg::DEF_MAX_QUADS,
    parameter int NUM_SLOTS = sqb_pkg::DEF_NUM_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel: one transaction per draw or flush request
    input  logic               i_valid,
    output logic               o_stall,
    input  sqb_pkg::t_in_item  i_item,
    // result channel: one transaction per vertex, bind or draw
    output logic               o_valid,
    input  logic               i_stall,
    output sqb_pkg::t_out_item o_result
);
    import sqb_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    // queue to back
    logic full;
    logic empty;
    logic pop;
    t_cmd head_cmd;

    // Front: takes a transaction whenever the queue has room, precomputes
    // the saturated right and top edges.
    sqb_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Two-entry queue decouples intake from the multi-cycle back end.
    sqb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Back: flush sequencing, slot table, vertex emission. The head command
    // stays in the queue until its final result is loaded; a flush of an empty batch is dropped with no result.
    sqb_back #(
        .MAX_QUADS (MAX_QUADS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// File: hw/rtl/sqb_checker.sv
// ----------------------------------------------------------------------------
// sqb_checker
// Port-level checks on the batcher result stream.
// ----------------------------------------------------------------------------
module sqb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input sqb_pkg::t_out_item o_result
);
    import sqb_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind == KIND_VERTEX) |->
            (o_result.bound_texture == '0) && (o_result.index_count == '0))
        else $error("vertex carries bind or draw data");

    a_bind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind == KIND_BIND) |->
            !o_result.last && (o_result.vert_x == '0) && (o_result.index_count == '0))
        else $error("bind marked last or carries vertex data");

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
